// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX   = 10'd1023;
  localparam logic [POS_W-1:0] HDR_CHARS = 10'd8;

  localparam logic [31:0] MASK_RESET = 32'hffff_ffff;
  localparam logic [31:0] LEN_SAT    = 32'hffff_fffc;

  // record types
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_SEG_ADDR  = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_LIN_ADDR  = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY     = 3'd1;
  localparam logic [2:0] ERR_TYPE      = 3'd2;
  localparam logic [2:0] ERR_RANGE     = 3'd3;
  localparam logic [2:0] ERR_MALFORMED = 3'd4;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // delimiter characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic        kind;
    logic [31:0] write_offset;
    logic [7:0]  write_byte;
    logic [31:0] start_address;
    logic [31:0] image_base;
    logic [31:0] image_length;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  // {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_COLON;
  endfunction

  function automatic logic has_payload(input logic [7:0] t);
    return t == REC_DATA || t == REC_SEG_ADDR || t == REC_START_SEG ||
           t == REC_LIN_ADDR || t == REC_START_LIN;
  endfunction

endpackage

// ===== rtl/ihex_if.sv =====
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] write_offset;
  logic [7:0]  write_byte;
  logic [31:0] start_address;
  logic [31:0] image_base;
  logic [31:0] image_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, output kind, output write_offset, output write_byte,
    output start_address, output image_base, output image_length,
    output error_code, output last, input ready
  );
  modport sink (
    input valid, input kind, input write_offset, input write_byte,
    input start_address, input image_base, input image_length,
    input error_code, input last, output ready
  );
endinterface

// ===== rtl/intel_hex_record_parser.sv =====
// Intel HEX record parser.
// in_item carries one text character per item plus an end_of_text flag on
// the final character. out_item carries results: a data write (kind 0) with
// image offset and byte for each data pair of a type 00 record, and one
// summary (kind 1) after the final character with start address, image
// base, image length and the sticky error code. last marks the final
// result caused by one input item.
// cfg_wr_en/cfg_wr_data write the flash size mask (all ones after reset);
// write it only while the parser is idle.
// Each character is parsed in the cycle it is accepted; its results land in
// a 4-entry output queue, visible in the next cycle. One item is taken per
// cycle while in_item.ready is high, that is while the queue has room for
// two; a stalled receiver thus holds the input off once three results wait.
// An end-of-text item with a trailing data byte yields two results.
// Reset (rst_n low at a clock edge) clears the parse state and the queue and
// sets the mask to all ones; the block accepts items on the next cycle.
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  ihex_in_if.sink     in_item,
  ihex_out_if.source  out_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0] mask_r;

  logic [ihex_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  rtype_r, rtype_nxt;
  logic [3:0]  hold_r, hold_nxt;
  logic [31:0] run_r, run_nxt;
  logic [31:0] base_r, base_nxt;
  logic        based_r, based_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] imglen_r, imglen_nxt;
  logic        seen_r, seen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] woff_r, woff_nxt;

  ihex_pkg::result_t fifo_r [ihex_pkg::FIFO_DEPTH];
  logic [ihex_pkg::PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [ihex_pkg::CNT_W-1:0] cnt_r;

  logic                 acc, pop, eot, delim;
  logic [7:0]           ch;
  logic [4:0]           hexd;
  logic [3:0]           nib;
  logic                 active;
  logic [ihex_pkg::POS_W-1:0] n_pay, need;
  logic [1:0]           n_push;
  ihex_pkg::result_t    res0, res1;

  logic [32:0] diff;
  logic [32:0] top_sum;
  logic        range_bad;
  logic [33:0] end_raw;
  logic [33:0] end_rnd;
  logic [31:0] end_val;
  logic [31:0] lin_masked;

  assign acc   = in_item.valid && in_item.ready;
  assign pop   = out_item.valid && out_item.ready;
  assign ch    = in_item.text_char;
  assign eot   = in_item.end_of_text;
  assign delim = ihex_pkg::is_delim(ch);
  assign hexd  = ihex_pkg::hex_decode(ch);
  assign nib   = hexd[3:0];
  assign n_pay = pos_r - ihex_pkg::HDR_CHARS;
  assign active = (pos_r < ihex_pkg::HDR_CHARS) ||
                  (ihex_pkg::has_payload(rtype_r) && n_pay < {1'b0, len_r, 1'b0});

  // data header checks, taken from the header registers before the type lands
  assign diff      = {1'b0, run_r} - {1'b0, base_r};
  assign top_sum   = {1'b0, run_r} + {25'd0, len_r};
  assign range_bad = diff[32] || (top_sum[32] && top_sum[31:0] != 32'd0);
  assign end_raw   = {2'b00, diff[31:0]} + {26'd0, len_r} + 34'd3;
  assign end_rnd   = {end_raw[33:2], 2'b00};
  assign end_val   = (end_rnd[33:32] != 2'b00) ? ihex_pkg::LEN_SAT : end_rnd[31:0];

  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    rtype_nxt  = rtype_r;
    hold_nxt   = hold_r;
    run_nxt    = run_r;
    base_nxt   = base_r;
    based_nxt  = based_r;
    entry_nxt  = entry_r;
    imglen_nxt = imglen_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    woff_nxt   = woff_r;
    n_push     = 2'd0;
    res0       = '0;
    res1       = '0;
    need       = ihex_pkg::HDR_CHARS;
    lin_masked = 32'd0;

    if (acc) begin
      if (!delim) begin
        seen_nxt = 1'b1;
        if (err_r == ihex_pkg::ERR_NONE) begin
          if (pos_r < ihex_pkg::POS_MAX) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (active) begin
            if (!hexd[4]) begin
              err_nxt = ihex_pkg::ERR_MALFORMED;
            end else if (pos_r < 10'd2) begin
              len_nxt = {len_r[3:0], nib};
            end else if (pos_r < 10'd6) begin
              addr_nxt = {addr_r[11:0], nib};
              if (pos_r == 10'd5) begin
                run_nxt = {run_r[31:16], addr_r[11:0], nib};
              end
            end else if (pos_r < ihex_pkg::HDR_CHARS) begin
              rtype_nxt = {rtype_r[3:0], nib};
              if (pos_r == 10'd7) begin
                if (rtype_nxt == ihex_pkg::REC_DATA) begin
                  based_nxt = 1'b1;
                  woff_nxt  = diff[31:0];
                  if (range_bad) begin
                    err_nxt = ihex_pkg::ERR_RANGE;
                  end else if (end_val > imglen_r) begin
                    imglen_nxt = end_val;
                  end
                end else if (rtype_nxt == ihex_pkg::REC_START_LIN) begin
                  entry_nxt = 32'd0;
                end else if (rtype_nxt > ihex_pkg::REC_START_LIN) begin
                  err_nxt = ihex_pkg::ERR_TYPE;
                end
              end
            end else if (rtype_r == ihex_pkg::REC_DATA) begin
              if (!n_pay[0]) begin
                hold_nxt = nib;
              end else begin
                res0.kind         = ihex_pkg::KIND_DATA;
                res0.write_offset = woff_r;
                res0.write_byte   = {hold_r, nib};
                res0.last         = !eot;
                woff_nxt          = woff_r + 32'd1;
                n_push            = 2'd1;
              end
            end else if (rtype_r == ihex_pkg::REC_START_LIN) begin
              entry_nxt = (n_pay == 10'd0) ? {28'd0, nib} : {entry_r[27:0], nib};
            end else begin
              run_nxt = (n_pay == 10'd0) ? {28'd0, nib} : {run_r[27:0], nib};
            end
          end
        end
      end

      // end of token
      if (delim || eot) begin
        if (pos_nxt != '0) begin
          if (err_nxt == ihex_pkg::ERR_NONE) begin
            need = ihex_pkg::HDR_CHARS +
                   (ihex_pkg::has_payload(rtype_nxt) ? {1'b0, len_nxt, 1'b0} : 10'd0);
            if (pos_nxt < ihex_pkg::HDR_CHARS || pos_nxt < need) begin
              err_nxt = ihex_pkg::ERR_MALFORMED;
            end else if (rtype_nxt == ihex_pkg::REC_SEG_ADDR) begin
              run_nxt = {run_nxt[27:0], 4'd0};
            end else if (rtype_nxt == ihex_pkg::REC_START_SEG) begin
              run_nxt = {run_nxt[23:0], 8'd0};
            end else if (rtype_nxt == ihex_pkg::REC_LIN_ADDR) begin
              run_nxt    = {run_nxt[15:0], 16'd0};
              lin_masked = run_nxt & mask_r;
              if (!based_nxt) begin
                base_nxt = lin_masked;
              end else if (lin_masked != base_nxt) begin
                err_nxt = ihex_pkg::ERR_RANGE;
              end
            end
          end
          pos_nxt   = '0;
          len_nxt   = 8'd0;
          addr_nxt  = 16'd0;
          rtype_nxt = 8'd0;
          hold_nxt  = 4'd0;
        end
      end

      if (eot) begin
        if (!seen_nxt && err_nxt == ihex_pkg::ERR_NONE) begin
          err_nxt = ihex_pkg::ERR_EMPTY;
        end
        res1.kind          = ihex_pkg::KIND_SUMMARY;
        res1.start_address = entry_nxt;
        res1.image_base    = base_nxt;
        res1.image_length  = imglen_nxt;
        res1.error_code    = err_nxt;
        res1.last          = 1'b1;
        if (n_push == 2'd0) begin
          res0   = res1;
          n_push = 2'd1;
        end else begin
          n_push = 2'd2;
        end
        pos_nxt    = '0;
        len_nxt    = 8'd0;
        addr_nxt   = 16'd0;
        rtype_nxt  = 8'd0;
        hold_nxt   = 4'd0;
        run_nxt    = 32'd0;
        base_nxt   = 32'd0;
        based_nxt  = 1'b0;
        entry_nxt  = 32'd0;
        imglen_nxt = 32'd0;
        seen_nxt   = 1'b0;
        err_nxt    = ihex_pkg::ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= ihex_pkg::MASK_RESET;
      pos_r    <= '0;
      len_r    <= 8'd0;
      addr_r   <= 16'd0;
      rtype_r  <= 8'd0;
      hold_r   <= 4'd0;
      run_r    <= 32'd0;
      base_r   <= 32'd0;
      based_r  <= 1'b0;
      entry_r  <= 32'd0;
      imglen_r <= 32'd0;
      seen_r   <= 1'b0;
      err_r    <= ihex_pkg::ERR_NONE;
      woff_r   <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      addr_r   <= addr_nxt;
      rtype_r  <= rtype_nxt;
      hold_r   <= hold_nxt;
      run_r    <= run_nxt;
      base_r   <= base_nxt;
      based_r  <= based_nxt;
      entry_r  <= entry_nxt;
      imglen_r <= imglen_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
      woff_r   <= woff_nxt;
    end
  end

  // result queue
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < ihex_pkg::FIFO_DEPTH; i++) begin
      if (n_push != 2'd0 && wr_ptr_r == ihex_pkg::PTR_W'(i)) begin
        fifo_r[i] <= res0;
      end
      if (n_push == 2'd2 && wr_ptr_p1 == ihex_pkg::PTR_W'(i)) begin
        fifo_r[i] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ihex_pkg::PTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + ihex_pkg::CNT_W'(n_push) - ihex_pkg::CNT_W'(pop);
    end
  end

  assign in_item.ready = cnt_r <= ihex_pkg::CNT_W'(ihex_pkg::FIFO_DEPTH - 2);

  assign out_item.valid         = cnt_r != '0;
  assign out_item.kind          = fifo_r[rd_ptr_r].kind;
  assign out_item.write_offset  = fifo_r[rd_ptr_r].write_offset;
  assign out_item.write_byte    = fifo_r[rd_ptr_r].write_byte;
  assign out_item.start_address = fifo_r[rd_ptr_r].start_address;
  assign out_item.image_base    = fifo_r[rd_ptr_r].image_base;
  assign out_item.image_length  = fifo_r[rd_ptr_r].image_length;
  assign out_item.error_code    = fifo_r[rd_ptr_r].error_code;
  assign out_item.last          = fifo_r[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ihex_pkg::CNT_W'(ihex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r == $past(cnt_r) + ihex_pkg::CNT_W'($past(n_push))
                     - ihex_pkg::CNT_W'($past(pop)))
    else $error("queue count out of step with pushes and pops");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eot) |=> (err_r == ihex_pkg::ERR_NONE && pos_r == '0 && !seen_r && !based_r))
    else $error("parse state not cleared after end of text");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.kind == ihex_pkg::KIND_SUMMARY) |-> out_item.last)
    else $error("summary not marked last");

  a_no_write_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0 && res0.kind == ihex_pkg::KIND_DATA) |-> err_r == ihex_pkg::ERR_NONE)
    else $error("data write while an error is pending");

endmodule
